@@ hdl/tcam_pkg.sv @@
// shared types, constants and helpers for the touch calibration and mapping block
`default_nettype none

package tcam_pkg;

  // raw panel span and screen size
  localparam int RAW_MIN_X     = 200;
  localparam int RAW_MAX_X     = 3900;
  localparam int RAW_MIN_Y     = 200;
  localparam int RAW_MAX_Y     = 3900;
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 480;
  localparam int SpanX         = RAW_MAX_X - RAW_MIN_X;
  localparam int SpanY         = RAW_MAX_Y - RAW_MIN_Y;

  localparam int PressLevel = 100;

  // field widths
  localparam int RawW     = 12;
  localparam int TgtW     = 9;
  localparam int ScrW     = 9;
  localparam int EvW      = 3;
  localparam int StepW    = 3;
  localparam int CfgAddrW = 3;
  localparam int InDataW  = 24;
  localparam int OutDataW = 24;

  // datapath widths
  localparam int CoefW   = 32;
  localparam int FracW   = 16;
  localparam int MaW     = 32;
  localparam int MbW     = 13;
  localparam int ProdW   = MaW + MbW;
  localparam int AccW    = 48;
  localparam int CrossW  = 25;
  localparam int DetW    = 27;
  localparam int NumW    = 36;
  localparam int DvdW    = NumW + FracW;
  localparam int CntW    = 6;

  // range mapping by reciprocal: screen size over raw span, scaled by 2^RngK, rounded up
  localparam int     RngK   = 24;
  localparam longint RecipX = (SpanX == 0) ? 64'd0 :
                              ((longint'(SCREEN_WIDTH) << RngK) + SpanX - 1) / SpanX;
  localparam longint RecipY = (SpanY == 0) ? 64'd0 :
                              ((longint'(SCREEN_HEIGHT) << RngK) + SpanY - 1) / SpanY;

  localparam logic [StepW-1:0] CalIdle = 3'd4;

  typedef enum logic [EvW-1:0] {
    EV_NONE     = 3'd0,
    EV_TOUCH    = 3'd1,
    EV_POINT    = 3'd2,
    EV_CAL_OK   = 3'd3,
    EV_CAL_FAIL = 3'd4
  } event_t;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_TX0 = 3'd0,
    CFG_TX1 = 3'd1,
    CFG_TX2 = 3'd2,
    CFG_TY0 = 3'd3,
    CFG_TY1 = 3'd4,
    CFG_TY2 = 3'd5
  } cfg_idx_t;

  // sums of products evaluated by the shared multiply-accumulate
  typedef enum logic [3:0] {
    Q_C0  = 4'd0,
    Q_C1  = 4'd1,
    Q_C2  = 4'd2,
    Q_NAX = 4'd3,
    Q_NBX = 4'd4,
    Q_NCX = 4'd5,
    Q_NAY = 4'd6,
    Q_NBY = 4'd7,
    Q_NCY = 4'd8,
    Q_MX  = 4'd9,
    Q_MY  = 4'd10,
    Q_RX  = 4'd11,
    Q_RY  = 4'd12
  } qty_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_MUL    = 3'd2,
    S_ADD    = 3'd3,
    S_POST   = 3'd4,
    S_CHECK  = 3'd5,
    S_DIV    = 3'd6,
    S_EMIT   = 3'd7
  } state_t;

  typedef logic [1:0] term_t;

  typedef struct packed {
    logic             load_in;
    logic             store_pt;
    logic [1:0]       pt_idx;
    logic             mul;
    logic             acc_add;
    logic             acc_first;
    qty_t             qty;
    term_t            term;
    logic             store_c;
    logic             div_coef;
    logic             store_coef;
    logic             map_store;
    logic             range_store;
    logic             emit;
    event_t           ev;
    logic [StepW-1:0] points;
    logic             calibrated;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic press;
    logic det_zero;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  function automatic term_t last_term(qty_t q);
    term_t t;
    case (q)
      Q_C0, Q_C1, Q_C2: t = 2'd1;
      Q_RX, Q_RY:       t = 2'd0;
      default:          t = 2'd2;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] coef_idx(qty_t q);
    logic [2:0] i;
    case (q)
      Q_NAX:   i = 3'd0;
      Q_NBX:   i = 3'd1;
      Q_NCX:   i = 3'd2;
      Q_NAY:   i = 3'd3;
      Q_NBY:   i = 3'd4;
      Q_NCY:   i = 3'd5;
      default: i = 3'd0;
    endcase
    return i;
  endfunction

  function automatic qty_t qty_next(qty_t q);
    qty_t n;
    case (q)
      Q_C0:    n = Q_C1;
      Q_C1:    n = Q_C2;
      Q_C2:    n = Q_NAX;
      Q_NAX:   n = Q_NBX;
      Q_NBX:   n = Q_NCX;
      Q_NCX:   n = Q_NAY;
      Q_NAY:   n = Q_NBY;
      Q_NBY:   n = Q_NCY;
      Q_MX:    n = Q_MY;
      Q_RX:    n = Q_RY;
      default: n = Q_C0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/touch_calibrate_and_map.sv @@
// top level of the touch calibration and mapping block
`default_nettype none

// Takes one raw touch sample per transaction and returns exactly one result per
// transaction. Only a press edge (both raw values above 100 after a non-press)
// does work. A sample that is no press edge, or a begin-calibration command,
// goes from decode to the result register with no arithmetic. A calibrated
// touch runs six multiply-accumulate steps through one 32x13 multiplier. An
// uncalibrated touch maps each axis with one multiply by a constant reciprocal
// of the raw span. The fourth calibration press solves the coefficients with
// six divisions of a 52-bit dividend in the one-bit-per-cycle divider, or fails
// without dividing on a zero determinant. The input is ready again in the cycle
// the result appears, so a new sample is accepted while a finished result still
// waits on the output; the next result then waits until the output is free. The
// targets may be written only while no transaction is in flight.

module touch_calibrate_and_map (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [tcam_pkg::CfgAddrW-1:0]        cfg_addr,
  input  wire  [tcam_pkg::TgtW-1:0]            cfg_wdata,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [tcam_pkg::InDataW-1:0]         in_tdata,   // raw_x, raw_y
  input  wire                                  in_tuser,   // mode
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [tcam_pkg::OutDataW-1:0]        out_tdata,  // screen_x, screen_y, points_taken, calibrated
  output logic [tcam_pkg::EvW-1:0]             out_tuser   // event_res
);
  import tcam_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tcam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcam_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

@@ hdl/tcam_ctrl.sv @@
// sequencer for press detection, calibration solve and touch mapping
`default_nettype none

module tcam_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  tcam_pkg::dp_sts_t sts,
  output tcam_pkg::dp_cmd_t cmd
);
  import tcam_pkg::*;

  state_t           state_r, state_nxt;
  logic             was_pressed_r, was_pressed_nxt;
  logic [StepW-1:0] cal_step_r, cal_step_nxt;
  logic             cal_valid_r, cal_valid_nxt;
  qty_t             qty_r, qty_nxt;
  term_t            term_r, term_nxt;
  event_t           ev_r, ev_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      was_pressed_r <= 1'b0;
      cal_step_r    <= CalIdle;
      cal_valid_r   <= 1'b0;
      qty_r         <= Q_C0;
      term_r        <= '0;
      ev_r          <= EV_NONE;
    end else begin
      state_r       <= state_nxt;
      was_pressed_r <= was_pressed_nxt;
      cal_step_r    <= cal_step_nxt;
      cal_valid_r   <= cal_valid_nxt;
      qty_r         <= qty_nxt;
      term_r        <= term_nxt;
      ev_r          <= ev_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    was_pressed_nxt = was_pressed_r;
    cal_step_nxt    = cal_step_r;
    cal_valid_nxt   = cal_valid_r;
    qty_nxt         = qty_r;
    term_nxt        = term_r;
    ev_nxt          = ev_r;
    in_tready       = 1'b0;
    cmd             = '0;
    cmd.qty         = qty_r;
    cmd.term        = term_r;
    cmd.ev          = ev_r;
    cmd.points      = cal_step_r;
    cmd.calibrated  = cal_valid_r;
    cmd.pt_idx      = cal_step_r[1:0];
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        ev_nxt    = EV_NONE;
        state_nxt = S_EMIT;
        term_nxt  = '0;
        if (sts.mode) begin
          cal_step_nxt = '0;
        end else if (!sts.press) begin
          was_pressed_nxt = 1'b0;
        end else if (!was_pressed_r) begin
          was_pressed_nxt = 1'b1;
          if (cal_step_r < CalIdle) begin
            cmd.store_pt = (cal_step_r < 3'd3);
            cal_step_nxt = cal_step_r + 3'd1;
            if (cal_step_r == 3'd3) begin
              qty_nxt   = Q_C0;
              state_nxt = S_MUL;
            end else begin
              ev_nxt = EV_POINT;
            end
          end else begin
            qty_nxt   = cal_valid_r ? Q_MX : Q_RX;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.acc_add   = 1'b1;
        cmd.acc_first = (term_r == 2'd0);
        if (term_r == last_term(qty_r)) begin
          state_nxt = S_POST;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_POST: begin
        term_nxt = '0;
        case (qty_r)
          Q_C0, Q_C1: begin
            cmd.store_c = 1'b1;
            qty_nxt     = qty_next(qty_r);
            state_nxt   = S_MUL;
          end
          Q_C2: begin
            cmd.store_c = 1'b1;
            state_nxt   = S_CHECK;
          end
          Q_MX: begin
            cmd.map_store = 1'b1;
            qty_nxt       = Q_MY;
            state_nxt     = S_MUL;
          end
          Q_MY: begin
            cmd.map_store = 1'b1;
            ev_nxt        = EV_TOUCH;
            state_nxt     = S_EMIT;
          end
          Q_RX: begin
            cmd.range_store = 1'b1;
            qty_nxt         = Q_RY;
            state_nxt       = S_MUL;
          end
          Q_RY: begin
            cmd.range_store = 1'b1;
            ev_nxt          = EV_TOUCH;
            state_nxt       = S_EMIT;
          end
          default: begin
            cmd.div_coef = 1'b1;
            state_nxt    = S_DIV;
          end
        endcase
      end
      S_CHECK: begin
        term_nxt = '0;
        if (sts.det_zero) begin
          ev_nxt    = EV_CAL_FAIL;
          state_nxt = S_EMIT;
        end else begin
          qty_nxt   = Q_NAX;
          state_nxt = S_MUL;
        end
      end
      S_DIV: begin
        term_nxt = '0;
        if (sts.div_done) begin
          case (qty_r)
            Q_NCY: begin
              cmd.store_coef = 1'b1;
              cal_valid_nxt  = 1'b1;
              ev_nxt         = EV_CAL_OK;
              state_nxt      = S_EMIT;
            end
            default: begin
              cmd.store_coef = 1'b1;
              qty_nxt        = qty_next(qty_r);
              state_nxt      = S_MUL;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/tcam_dp.sv @@
// datapath: targets, captured points, shared multiply-accumulate, serial divider, result register
`default_nettype none

module tcam_dp (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [tcam_pkg::CfgAddrW-1:0]       cfg_addr,
  input  wire  [tcam_pkg::TgtW-1:0]           cfg_wdata,
  input  wire                                 in_tuser,
  input  wire  [tcam_pkg::InDataW-1:0]        in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [tcam_pkg::EvW-1:0]            out_tuser,
  output logic [tcam_pkg::OutDataW-1:0]       out_tdata,
  input  tcam_pkg::dp_cmd_t                   cmd,
  output tcam_pkg::dp_sts_t                   sts
);
  import tcam_pkg::*;

  logic [TgtW-1:0] tgt_x_r [3];
  logic [TgtW-1:0] tgt_y_r [3];

  logic            mode_r;
  logic [RawW-1:0] rx_r, ry_r;
  logic [RawW-1:0] cal_x_r [3];
  logic [RawW-1:0] cal_y_r [3];

  logic signed [CrossW-1:0] c_r [3];
  logic signed [CoefW-1:0]  coef_r [6];
  logic signed [ProdW-1:0]  p_r;
  logic signed [AccW-1:0]   acc_r;

  logic [DvdW-1:0]   dvd_r;
  logic [DetW-1:0]   rem_r;
  logic [DetW-1:0]   dvs_r;
  logic [CntW-1:0]   cnt_r;
  logic              neg_r;

  logic [ScrW-1:0]   sx_r, sy_r;
  logic              out_valid_r;
  event_t            out_ev_r;
  logic [OutDataW-1:0] out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_x_r[0] <= 9'd20;
      tgt_x_r[1] <= 9'd300;
      tgt_x_r[2] <= 9'd160;
      tgt_y_r[0] <= 9'd20;
      tgt_y_r[1] <= 9'd240;
      tgt_y_r[2] <= 9'd460;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TX0: tgt_x_r[0] <= cfg_wdata;
        CFG_TX1: tgt_x_r[1] <= cfg_wdata;
        CFG_TX2: tgt_x_r[2] <= cfg_wdata;
        CFG_TY0: tgt_y_r[0] <= cfg_wdata;
        CFG_TY1: tgt_y_r[1] <= cfg_wdata;
        CFG_TY2: tgt_y_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input capture and calibration points
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_tuser;
      rx_r   <= in_tdata[RawW-1:0];
      ry_r   <= in_tdata[2*RawW-1:RawW];
    end
    if (cmd.store_pt) begin
      cal_x_r[cmd.pt_idx] <= rx_r;
      cal_y_r[cmd.pt_idx] <= ry_r;
    end
  end

  // operand selection
  logic                    axis_y;
  logic [TgtW-1:0]         tsel [3];
  logic signed [MbW-1:0]   ys [3];
  logic signed [MbW-1:0]   ts [3];
  logic [MaW-1:0]          xm [3];
  logic [MaW-1:0]          tm [3];
  logic signed [MbW-1:0]   rx_s, ry_s;
  logic signed [MaW-1:0]   ma;
  logic signed [MbW-1:0]   mb;

  assign axis_y = (cmd.qty == Q_NAY) || (cmd.qty == Q_NBY) || (cmd.qty == Q_NCY);
  assign rx_s   = signed'({1'b0, rx_r});
  assign ry_s   = signed'({1'b0, ry_r});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tsel[k] = axis_y ? tgt_y_r[k] : tgt_x_r[k];
      ys[k]   = signed'({1'b0, cal_y_r[k]});
      ts[k]   = signed'({{(MbW-TgtW){1'b0}}, tsel[k]});
      xm[k]   = {{(MaW-RawW){1'b0}}, cal_x_r[k]};
      tm[k]   = {{(MaW-TgtW){1'b0}}, tsel[k]};
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.qty)
      Q_C0: begin
        if (cmd.term == 2'd0) begin ma = xm[1]; mb = ys[2]; end
        else begin ma = xm[2]; mb = -ys[1]; end
      end
      Q_C1: begin
        if (cmd.term == 2'd0) begin ma = xm[2]; mb = ys[0]; end
        else begin ma = xm[0]; mb = -ys[2]; end
      end
      Q_C2: begin
        if (cmd.term == 2'd0) begin ma = xm[0]; mb = ys[1]; end
        else begin ma = xm[1]; mb = -ys[0]; end
      end
      Q_NAX, Q_NAY: begin
        case (cmd.term)
          2'd0:    begin ma = tm[0]; mb = ys[1] - ys[2]; end
          2'd1:    begin ma = tm[1]; mb = ys[2] - ys[0]; end
          default: begin ma = tm[2]; mb = ys[0] - ys[1]; end
        endcase
      end
      Q_NBX, Q_NBY: begin
        case (cmd.term)
          2'd0:    begin ma = xm[0]; mb = ts[1] - ts[2]; end
          2'd1:    begin ma = xm[1]; mb = ts[2] - ts[0]; end
          default: begin ma = xm[2]; mb = ts[0] - ts[1]; end
        endcase
      end
      Q_NCX, Q_NCY: begin
        case (cmd.term)
          2'd0:    begin ma = {{(MaW-CrossW){c_r[0][CrossW-1]}}, c_r[0]}; mb = ts[0]; end
          2'd1:    begin ma = {{(MaW-CrossW){c_r[1][CrossW-1]}}, c_r[1]}; mb = ts[1]; end
          default: begin ma = {{(MaW-CrossW){c_r[2][CrossW-1]}}, c_r[2]}; mb = ts[2]; end
        endcase
      end
      Q_MX: begin
        case (cmd.term)
          2'd0:    begin ma = coef_r[0]; mb = rx_s; end
          2'd1:    begin ma = coef_r[1]; mb = ry_s; end
          default: begin ma = coef_r[2]; mb = MbW'(1); end
        endcase
      end
      Q_MY: begin
        case (cmd.term)
          2'd0:    begin ma = coef_r[3]; mb = rx_s; end
          2'd1:    begin ma = coef_r[4]; mb = ry_s; end
          default: begin ma = coef_r[5]; mb = MbW'(1); end
        endcase
      end
      Q_RX: begin ma = MaW'(RecipX); mb = rx_s - MbW'(RAW_MIN_X); end
      Q_RY: begin ma = MaW'(RecipY); mb = ry_s - MbW'(RAW_MIN_Y); end
      default: ;
    endcase
  end

  // multiply, then accumulate
  always_ff @(posedge clk) begin
    if (cmd.mul) p_r <= ma * mb;
    if (cmd.acc_add) begin
      acc_r <= (cmd.acc_first ? AccW'(0) : acc_r) + {{(AccW-ProdW){p_r[ProdW-1]}}, p_r};
    end
    if (cmd.store_c) c_r[cmd.qty[1:0]] <= acc_r[CrossW-1:0];
  end

  // determinant
  logic signed [DetW-1:0] det;
  logic [DetW-1:0]        det_mag;
  logic [AccW-1:0]        acc_mag;

  assign det     = DetW'(c_r[0]) + DetW'(c_r[1]) + DetW'(c_r[2]);
  assign det_mag = det[DetW-1] ? DetW'(-det) : det;
  assign acc_mag = acc_r[AccW-1] ? AccW'(-acc_r) : acc_r;

  // restoring divider, one quotient bit per cycle
  logic [DetW:0] rem_sh;
  logic          rem_ge;
  logic [DetW:0] rem_sub;

  assign rem_sh  = {rem_r, dvd_r[DvdW-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_coef) begin
      cnt_r <= CntW'(DvdW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_coef) begin
      dvd_r <= {acc_mag[NumW-1:0], {FracW{1'b0}}};
      dvs_r <= det_mag;
      rem_r <= '0;
      neg_r <= acc_r[AccW-1] ^ det[DetW-1];
    end else if (cnt_r != '0) begin
      rem_r <= rem_ge ? rem_sub[DetW-1:0] : rem_sh[DetW-1:0];
      dvd_r <= {dvd_r[DvdW-2:0], rem_ge};
    end
  end

  // saturate quotient into a coefficient
  localparam logic [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

  logic [CoefW-1:0] coef_val;

  always_comb begin
    if (!neg_r) begin
      coef_val = (dvd_r > {{(DvdW-CoefW){1'b0}}, CoefMax}) ? CoefMax : dvd_r[CoefW-1:0];
    end else begin
      coef_val = (dvd_r > {{(DvdW-CoefW){1'b0}}, CoefMin}) ? CoefMin : -dvd_r[CoefW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_coef) coef_r[coef_idx(cmd.qty)] <= coef_val;
  end

  // screen position from the affine sum or the range reciprocal product
  localparam int TrW = AccW - FracW;
  localparam int RqW = AccW - RngK;

  logic            is_x;
  logic [TrW-1:0]  lim;
  logic [TrW-1:0]  trunc;
  logic            rnd;
  logic [ScrW-1:0] map_val;
  logic [ScrW-1:0] rng_val;
  logic            span_zero;

  assign is_x      = (cmd.qty == Q_MX) || (cmd.qty == Q_RX);
  assign lim       = is_x ? TrW'(SCREEN_WIDTH - 1) : TrW'(SCREEN_HEIGHT - 1);
  assign rnd       = acc_r[AccW-1] && (acc_r[FracW-1:0] != '0);
  assign trunc     = acc_r[AccW-1:FracW] + {{(TrW-1){1'b0}}, rnd};
  assign span_zero = is_x ? (SpanX == 0) : (SpanY == 0);

  always_comb begin
    if (trunc[TrW-1]) begin
      map_val = '0;
    end else if (trunc > lim) begin
      map_val = lim[ScrW-1:0];
    end else begin
      map_val = trunc[ScrW-1:0];
    end
    if (span_zero || acc_r[AccW-1]) begin
      rng_val = '0;
    end else if (acc_r[AccW-1:RngK] > lim[RqW-1:0]) begin
      rng_val = lim[ScrW-1:0];
    end else begin
      rng_val = acc_r[RngK+ScrW-1:RngK];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_store || cmd.range_store) begin
      if (is_x) sx_r <= cmd.map_store ? map_val : rng_val;
      else      sy_r <= cmd.map_store ? map_val : rng_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ev_r   <= cmd.ev;
      out_data_r <= {{(OutDataW-2*ScrW-StepW-1){1'b0}}, cmd.calibrated, cmd.points,
                     (cmd.ev == EV_TOUCH) ? sy_r : {ScrW{1'b0}},
                     (cmd.ev == EV_TOUCH) ? sx_r : {ScrW{1'b0}}};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = out_data_r;

  assign sts.mode     = mode_r;
  assign sts.press    = (rx_r > RawW'(PressLevel)) && (ry_r > RawW'(PressLevel));
  assign sts.det_zero = (det == '0);
  assign sts.div_done = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

`default_nettype wire

@@ hdl/tcam_chk.sv @@
// port checker for the touch calibration and mapping block
`default_nettype none

module tcam_chk (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 out_tvalid,
  input wire                                 out_tready,
  input wire [tcam_pkg::OutDataW-1:0]        out_tdata,
  input wire [tcam_pkg::EvW-1:0]             out_tuser
);
  import tcam_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_screen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != EV_TOUCH) |-> (out_tdata[2*ScrW-1:0] == '0))
    else $error("screen position set on a non-touch result");

  a_screen_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[ScrW-1:0] < ScrW'(SCREEN_WIDTH))
                && (out_tdata[2*ScrW-1:ScrW] < ScrW'(SCREEN_HEIGHT)))
    else $error("screen position outside the screen");

  a_cal_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_CAL_OK) |->
      out_tdata[2*ScrW+StepW] && (out_tdata[2*ScrW+StepW-1:2*ScrW] == CalIdle))
    else $error("calibration success without valid coefficients");

  a_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_POINT) |->
      (out_tdata[2*ScrW+StepW-1:2*ScrW] == 3'd1) || (out_tdata[2*ScrW+StepW-1:2*ScrW] == 3'd2)
      || (out_tdata[2*ScrW+StepW-1:2*ScrW] == 3'd3))
    else $error("point stored with a bad point count");

endmodule

bind touch_calibrate_and_map tcam_chk u_chk (.*);

`default_nettype wire
